FILE: rtl/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared widths, register indexes, codes and sideband types of the
// world-to-screen projection block.
// ----------------------------------------------------------------------------
package wtsp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int IDX_W         = 4;
   localparam int SIZE_W        = 14;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int NUM_COEF      = 12;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = 14'd1920;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = 14'd1080;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 4'd1;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   localparam logic [1:0] COL_X = 2'd0;
   localparam logic [1:0] COL_Y = 2'd1;
   localparam logic [1:0] COL_Z = 2'd2;
   localparam logic [1:0] COL_W = 2'd3;

   typedef struct packed {
      logic vis;
      logic neg;
   } div_side_type;

endpackage

FILE: rtl/wtsp_req_if.sv
// ----------------------------------------------------------------------------
// wtsp_req_if
// Request channel: matrix element loads and world points to project.
// ----------------------------------------------------------------------------
interface wtsp_req_if;
   import wtsp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [IDX_W-1:0]          element_index;
   logic signed [COORD_W-1:0] element_value;
   logic signed [COORD_W-1:0] world_x;
   logic signed [COORD_W-1:0] world_y;
   logic signed [COORD_W-1:0] world_z;

   modport source (output valid, mode, element_index, element_value,
                   world_x, world_y, world_z, input ready);
   modport sink   (input valid, mode, element_index, element_value,
                   world_x, world_y, world_z, output ready);
endinterface

FILE: rtl/wtsp_rsp_if.sv
// ----------------------------------------------------------------------------
// wtsp_rsp_if
// Response channel: visibility flag and pixel position.
// ----------------------------------------------------------------------------
interface wtsp_rsp_if;
   import wtsp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      visible;
   logic signed [COORD_W-1:0] screen_x;
   logic signed [COORD_W-1:0] screen_y;

   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

FILE: rtl/wtsp_csr_if.sv
// ----------------------------------------------------------------------------
// wtsp_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface wtsp_csr_if;
   import wtsp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/wtsp_divider.sv
// ----------------------------------------------------------------------------
// wtsp_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module wtsp_divider #(
   parameter int QW = 32,
   parameter int DW = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_vld,
   input  logic [QW-1:0]              in_num,
   input  logic [DW-1:0]              in_den,
   input  wtsp_pkg::div_side_type     in_side,
   output logic                       out_vld,
   output logic [QW-1:0]              out_quo,
   output wtsp_pkg::div_side_type     out_side
);
   import wtsp_pkg::*;

   logic                vld_ff  [QW];
   logic [DW-1:0]       rem_ff  [QW];
   logic [QW-1:0]       num_ff  [QW];
   logic [QW-1:0]       quo_ff  [QW];
   logic [DW-1:0]       den_ff  [QW];
   div_side_type        side_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic          vld_src;
      logic [DW-1:0] rem_src;
      logic [QW-1:0] num_src;
      logic [QW-1:0] quo_src;
      logic [DW-1:0] den_src;
      div_side_type  side_src;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (g == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rem_src  = '0;
         assign num_src  = in_num;
         assign quo_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign num_src  = num_ff[g-1];
         assign quo_src  = quo_ff[g-1];
         assign den_src  = den_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      assign trial  = {rem_src, num_src[QW-1]};
      assign ge     = trial >= {1'b0, den_src};
      assign rem_in = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
      assign quo_in = {quo_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (adv) begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= rem_in;
            num_ff[g]  <= {num_src[QW-2:0], 1'b0};
            quo_ff[g]  <= quo_in;
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_quo  = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

FILE: rtl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of world points to pixel positions in fixed point.
// ----------------------------------------------------------------------------
// Pipeline from request beat to response beat: two dot-product stages,
//   one divider stage per quotient bit, two scaling stages and the
//   output register.
// Throughput: one beat per cycle; the whole pipeline holds while rsp waits.
// Reset: coefficient store cleared, width 1920, height 1080, pipeline empty.
module world_to_screen_projection #(
   parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wtsp_req_if.sink    req_chan,
   wtsp_rsp_if.source  rsp_chan,
   wtsp_csr_if.sink    csr_chan
);
   import wtsp_pkg::*;

   localparam int SUM_W = 66 - FRAC_BITS;
   localparam int DW    = SUM_W - 1;
   localparam int QW    = 32 + FRAC_BITS;
   localparam int HI_W  = QW - 24;
   localparam int PW    = QW + SIZE_W;
   localparam int HW    = PW + 2;
   localparam longint ONE_FX = 64'sd1 <<< FRAC_BITS;
   localparam longint W_MIN  = (ONE_FX + 99) / 100;

   localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh80000000;

   logic adv;

   // registers
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic signed [COORD_W-1:0] coef_ff [NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_chan.valid && csr_chan.ready) begin
         if (csr_chan.index == CSR_SCREEN_WIDTH) begin
            width_ff <= csr_chan.data[SIZE_W-1:0];
         end
         if (csr_chan.index == CSR_SCREEN_HEIGHT) begin
            height_ff <= csr_chan.data[SIZE_W-1:0];
         end
      end
   end
   assign csr_chan.ready = 1'b1;

   // coefficient load
   logic       req_acc;
   logic [1:0] ld_row, ld_col;
   logic [3:0] ld_slot;
   logic signed [COORD_W-1:0] ld_val;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign ld_row  = req_chan.element_index[3:2];
   assign ld_col  = req_chan.element_index[1:0];

   always_comb begin
      ld_slot = 4'(ld_row) * 4'd3 + ((ld_col == COL_W) ? 4'd2 : 4'(ld_col));
      ld_val  = req_chan.element_value;
      if (ld_col == COL_Y) begin
         ld_val = (req_chan.element_value == S32_MIN) ? S32_MAX : -req_chan.element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (req_acc && req_chan.mode == MODE_LOAD && ld_col != COL_Z) begin
         coef_ff[ld_slot] <= ld_val;
      end
   end

   // stage 1: products
   logic                p1_vld_ff;
   logic signed [63:0]  prod_ff [9];
   logic signed [COORD_W-1:0] bias_ff [3];
   logic signed [COORD_W-1:0] pt [3];

   assign pt[0] = req_chan.world_x;
   assign pt[1] = req_chan.world_y;
   assign pt[2] = req_chan.world_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= req_acc && req_chan.mode == MODE_PROJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r*3+k] <= 64'(coef_ff[r*3+k]) * 64'(pt[r]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            bias_ff[k] <= coef_ff[9+k];
         end
      end
   end

   // stage 2: sums, saturation, visibility
   logic signed [SUM_W-1:0] sum [3];
   logic signed [63:0]      shp [9];
   logic signed [COORD_W-1:0] sat_x, sat_y;
   logic p2_vld_ff, vis_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic signed [SUM_W-1:0]   w_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         shp[i] = prod_ff[i] >>> FRAC_BITS;
      end
      for (int k = 0; k < 3; k++) begin
         sum[k] = $signed(shp[k][SUM_W-1:0]) + $signed(shp[3+k][SUM_W-1:0])
                + $signed(shp[6+k][SUM_W-1:0])
                + $signed({{(SUM_W-COORD_W){bias_ff[k][COORD_W-1]}}, bias_ff[k]});
      end
      if (sum[0][SUM_W-1:COORD_W-1] == '0 || sum[0][SUM_W-1:COORD_W-1] == '1) begin
         sat_x = sum[0][COORD_W-1:0];
      end else begin
         sat_x = sum[0][SUM_W-1] ? S32_MIN : S32_MAX;
      end
      if (sum[1][SUM_W-1:COORD_W-1] == '0 || sum[1][SUM_W-1:COORD_W-1] == '1) begin
         sat_y = sum[1][COORD_W-1:0];
      end else begin
         sat_y = sum[1][SUM_W-1] ? S32_MIN : S32_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (adv) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff  <= sat_x;
         cy_ff  <= sat_y;
         w_ff   <= sum[2];
         vis_ff <= sum[2] >= $signed(SUM_W'(W_MIN));
      end
   end

   // divider inputs
   logic [COORD_W-1:0] mag_x, mag_y;
   logic [DW-1:0]      den;
   div_side_type       side_x_in, side_y_in, side_x, side_y;
   logic [QW-1:0]      quo_x, quo_y;
   logic               dx_vld, dy_vld;

   assign mag_x = cx_ff[COORD_W-1] ? COORD_W'(-cx_ff) : cx_ff;
   assign mag_y = cy_ff[COORD_W-1] ? COORD_W'(-cy_ff) : cy_ff;
   assign den   = vis_ff ? w_ff[DW-1:0] : DW'(1);
   assign side_x_in = '{vis: vis_ff, neg: cx_ff[COORD_W-1]};
   assign side_y_in = '{vis: vis_ff, neg: cy_ff[COORD_W-1]};

   wtsp_divider #(.QW(QW), .DW(DW)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (p2_vld_ff),
      .in_num   ({mag_x, {FRAC_BITS{1'b0}}}),
      .in_den   (den),
      .in_side  (side_x_in),
      .out_vld  (dx_vld),
      .out_quo  (quo_x),
      .out_side (side_x)
   );

   wtsp_divider #(.QW(QW), .DW(DW)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (p2_vld_ff),
      .in_num   ({mag_y, {FRAC_BITS{1'b0}}}),
      .in_den   (den),
      .in_side  (side_y_in),
      .out_vld  (dy_vld),
      .out_quo  (quo_y),
      .out_side (side_y)
   );

   // stage M1: partial products of quotient and size
   logic m1_vld_ff;
   logic [HI_W+SIZE_W-1:0] ppx_hi_ff, ppy_hi_ff;
   logic [24+SIZE_W-1:0]   ppx_lo_ff, ppy_lo_ff;
   div_side_type           m1_sx_ff, m1_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= dx_vld && dy_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ppx_hi_ff <= (HI_W+SIZE_W)'(quo_x[QW-1:24]) * (HI_W+SIZE_W)'(width_ff);
         ppx_lo_ff <= (24+SIZE_W)'(quo_x[23:0]) * (24+SIZE_W)'(width_ff);
         ppy_hi_ff <= (HI_W+SIZE_W)'(quo_y[QW-1:24]) * (HI_W+SIZE_W)'(height_ff);
         ppy_lo_ff <= (24+SIZE_W)'(quo_y[23:0]) * (24+SIZE_W)'(height_ff);
         m1_sx_ff  <= side_x;
         m1_sy_ff  <= side_y;
      end
   end

   // stage M2: combine, sign, round
   logic [PW-1:0]          mag_px, mag_py;
   logic signed [HW-1:0]   rnd_x, rnd_y;
   logic m2_vld_ff;
   logic signed [HW-1:0]   half_x_ff, half_y_ff;
   div_side_type           m2_sx_ff, m2_sy_ff;

   always_comb begin
      mag_px = (PW'(ppx_hi_ff) << 24) + PW'(ppx_lo_ff);
      mag_py = (PW'(ppy_hi_ff) << 24) + PW'(ppy_lo_ff);
      rnd_x  = (m1_sx_ff.neg ? -$signed(HW'(mag_px)) : $signed(HW'(mag_px)))
             + $signed(HW'(ONE_FX));
      rnd_y  = (m1_sy_ff.neg ? -$signed(HW'(mag_py)) : $signed(HW'(mag_py)))
             + $signed(HW'(ONE_FX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         half_x_ff <= rnd_x >>> 1;
         half_y_ff <= rnd_y >>> 1;
         m2_sx_ff  <= m1_sx_ff;
         m2_sy_ff  <= m1_sy_ff;
      end
   end

   // output stage: centre offset and saturation
   logic signed [HW:0]        cen_x, cen_y, pos_x, pos_y;
   logic signed [COORD_W-1:0] sat_px, sat_py;
   logic                      out_vld_ff, out_vis_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;

   always_comb begin
      cen_x = $signed((HW+1)'(width_ff >> 1) << FRAC_BITS);
      cen_y = $signed((HW+1)'(height_ff >> 1) << FRAC_BITS);
      pos_x = cen_x + (HW+1)'(half_x_ff);
      pos_y = cen_y - (HW+1)'(half_y_ff);
      if (pos_x[HW:COORD_W-1] == '0 || pos_x[HW:COORD_W-1] == '1) begin
         sat_px = pos_x[COORD_W-1:0];
      end else begin
         sat_px = pos_x[HW] ? S32_MIN : S32_MAX;
      end
      if (pos_y[HW:COORD_W-1] == '0 || pos_y[HW:COORD_W-1] == '1) begin
         sat_py = pos_y[COORD_W-1:0];
      end else begin
         sat_py = pos_y[HW] ? S32_MIN : S32_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_vis_ff <= m2_sx_ff.vis;
         out_x_ff   <= m2_sx_ff.vis ? sat_px : '0;
         out_y_ff   <= m2_sx_ff.vis ? sat_py : '0;
      end
   end

   assign adv              = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready   = adv;
   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.visible = out_vis_ff;
   assign rsp_chan.screen_x = out_x_ff;
   assign rsp_chan.screen_y = out_y_ff;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_vis_ff |-> out_x_ff == '0 && out_y_ff == '0)
      else $error("hidden point with nonzero position");

   a_load_no_item: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_chan.mode == MODE_LOAD |=> !p1_vld_ff)
      else $error("load beat entered the projection pipeline");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> out_vld_ff)
      else $error("request stalled with empty output register");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dx_vld == dy_vld && (!dx_vld || side_x.vis == side_y.vis))
      else $error("divider lanes out of step");

   a_width_write: assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid && csr_chan.ready && csr_chan.index == CSR_SCREEN_WIDTH
      |=> width_ff == $past(csr_chan.data[SIZE_W-1:0]))
      else $error("width register write lost");

endmodule
